// ===== rtl/cbe_pkg.sv =====
package cbe_pkg;

  // Field widths.
  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int U_W             = PARAM_FRAC_BITS + 1;

  // Widths of the de Casteljau levels, exact at every level.
  localparam int P1_W = COORD_BITS + U_W;
  localparam int B_W  = COORD_BITS + PARAM_FRAC_BITS;
  localparam int P2_W = B_W + U_W;
  localparam int C_W  = COORD_BITS + 2 * PARAM_FRAC_BITS;
  localparam int D_W  = COORD_BITS + 3 * PARAM_FRAC_BITS;

  // The last level is split into a low and a high half of each second-level value.
  localparam int CL_W = C_W / 2;
  localparam int CH_W = C_W - CL_W;
  localparam int PL_W = CL_W + U_W;
  localparam int PH_W = CH_W + U_W;
  localparam int SL_W = PL_W + 1;
  localparam int SH_W = PH_W + 1;
  localparam int DS_W = C_W + U_W + 1;

  // Rounding and result extraction.
  localparam int FRAC_W = 3 * PARAM_FRAC_BITS;
  localparam int R_W    = COORD_BITS + 1;

  localparam logic [U_W-1:0]  PARAM_ONE  = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
  localparam logic [DS_W-1:0] ROUND_HALF = DS_W'(1) << (FRAC_W - 1);

  typedef logic [U_W-1:0]        param_t;
  typedef logic [COORD_BITS-1:0] coord_t;

  // First lerp level, registered.
  typedef struct packed {
    logic           valid;
    param_t         u;
    param_t         v;
    logic [B_W-1:0] b0;
    logic [B_W-1:0] b1;
    logic [B_W-1:0] b2;
  } lvl1_t;

  // Second lerp level, registered.
  typedef struct packed {
    logic           valid;
    param_t         u;
    param_t         v;
    logic [C_W-1:0] c0;
    logic [C_W-1:0] c1;
  } lvl2_t;

endpackage

// ===== rtl/cbe_front.sv =====
module cbe_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [cbe_pkg::U_W-1:0]             u_param,
  input  logic signed [cbe_pkg::COORD_BITS-1:0] point_0,
  input  logic signed [cbe_pkg::COORD_BITS-1:0] point_1,
  input  logic signed [cbe_pkg::COORD_BITS-1:0] point_2,
  input  logic signed [cbe_pkg::COORD_BITS-1:0] point_3,
  output cbe_pkg::lvl1_t                      lvl1
);

  cbe_pkg::param_t u_sat;
  cbe_pkg::param_t v_cmp;
  cbe_pkg::coord_t q0, q1, q2, q3;
  logic [cbe_pkg::P1_W-1:0] s0, s1, s2;

  // Clamp the parameter to 1.0 and form its complement.
  assign u_sat = (u_param > cbe_pkg::PARAM_ONE) ? cbe_pkg::PARAM_ONE : u_param;
  assign v_cmp = cbe_pkg::PARAM_ONE - u_sat;

  // Offset-binary coordinates keep every product unsigned.
  assign q0 = {~point_0[cbe_pkg::COORD_BITS-1], point_0[cbe_pkg::COORD_BITS-2:0]};
  assign q1 = {~point_1[cbe_pkg::COORD_BITS-1], point_1[cbe_pkg::COORD_BITS-2:0]};
  assign q2 = {~point_2[cbe_pkg::COORD_BITS-1], point_2[cbe_pkg::COORD_BITS-2:0]};
  assign q3 = {~point_3[cbe_pkg::COORD_BITS-1], point_3[cbe_pkg::COORD_BITS-2:0]};

  // First level: each pair of neighbors blended by u and 1-u.
  assign s0 = cbe_pkg::P1_W'(q0) * cbe_pkg::P1_W'(u_sat)
            + cbe_pkg::P1_W'(q1) * cbe_pkg::P1_W'(v_cmp);
  assign s1 = cbe_pkg::P1_W'(q1) * cbe_pkg::P1_W'(u_sat)
            + cbe_pkg::P1_W'(q2) * cbe_pkg::P1_W'(v_cmp);
  assign s2 = cbe_pkg::P1_W'(q2) * cbe_pkg::P1_W'(u_sat)
            + cbe_pkg::P1_W'(q3) * cbe_pkg::P1_W'(v_cmp);

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl1.valid <= 1'b0;
    end else begin
      lvl1.valid <= in_valid;
    end
    lvl1.u  <= u_sat;
    lvl1.v  <= v_cmp;
    lvl1.b0 <= s0[cbe_pkg::B_W-1:0];
    lvl1.b1 <= s1[cbe_pkg::B_W-1:0];
    lvl1.b2 <= s2[cbe_pkg::B_W-1:0];
  end

endmodule

// ===== rtl/cbe_mid.sv =====
module cbe_mid (
  input  logic           clk,
  input  logic           rst,
  input  cbe_pkg::lvl1_t lvl1,
  output cbe_pkg::lvl2_t lvl2
);

  logic [cbe_pkg::P2_W-1:0] s0, s1;

  // Second level: blend the three first-level values down to two.
  assign s0 = cbe_pkg::P2_W'(lvl1.b0) * cbe_pkg::P2_W'(lvl1.u)
            + cbe_pkg::P2_W'(lvl1.b1) * cbe_pkg::P2_W'(lvl1.v);
  assign s1 = cbe_pkg::P2_W'(lvl1.b1) * cbe_pkg::P2_W'(lvl1.u)
            + cbe_pkg::P2_W'(lvl1.b2) * cbe_pkg::P2_W'(lvl1.v);

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl2.valid <= 1'b0;
    end else begin
      lvl2.valid <= lvl1.valid;
    end
    lvl2.u  <= lvl1.u;
    lvl2.v  <= lvl1.v;
    lvl2.c0 <= s0[cbe_pkg::C_W-1:0];
    lvl2.c1 <= s1[cbe_pkg::C_W-1:0];
  end

endmodule

// ===== rtl/cbe_tail.sv =====
module cbe_tail (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cbe_pkg::lvl2_t                        lvl2,
  output logic                                  done,
  output logic signed [cbe_pkg::COORD_BITS-1:0] curve_coord
);

  // Partial products of the last level.
  logic                      pp_valid;
  logic [cbe_pkg::PH_W-1:0]  ph0, ph1;
  logic [cbe_pkg::PL_W-1:0]  pl0, pl1;

  // Partial sums.
  logic                      ps_valid;
  logic [cbe_pkg::SH_W-1:0]  sh;
  logic [cbe_pkg::SL_W-1:0]  sl;

  logic [cbe_pkg::DS_W-1:0]  d_sum;
  logic [cbe_pkg::R_W-1:0]   r_val;
  cbe_pkg::coord_t           r_sat;

  // Third level in halves: each second-level value split into high and low parts.
  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= lvl2.valid;
    end
    ph0 <= cbe_pkg::PH_W'(lvl2.c0[cbe_pkg::C_W-1:cbe_pkg::CL_W])
         * cbe_pkg::PH_W'(lvl2.u);
    pl0 <= cbe_pkg::PL_W'(lvl2.c0[cbe_pkg::CL_W-1:0]) * cbe_pkg::PL_W'(lvl2.u);
    ph1 <= cbe_pkg::PH_W'(lvl2.c1[cbe_pkg::C_W-1:cbe_pkg::CL_W])
         * cbe_pkg::PH_W'(lvl2.v);
    pl1 <= cbe_pkg::PL_W'(lvl2.c1[cbe_pkg::CL_W-1:0]) * cbe_pkg::PL_W'(lvl2.v);
  end

  // Add the matching halves of the two terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      ps_valid <= 1'b0;
    end else begin
      ps_valid <= pp_valid;
    end
    sh <= cbe_pkg::SH_W'(ph0) + cbe_pkg::SH_W'(ph1);
    sl <= cbe_pkg::SL_W'(pl0) + cbe_pkg::SL_W'(pl1);
  end

  // Recombine, round half up, and clamp to the coordinate range.
  assign d_sum = (cbe_pkg::DS_W'(sh) << cbe_pkg::CL_W) + cbe_pkg::DS_W'(sl)
               + cbe_pkg::ROUND_HALF;
  assign r_val = d_sum[cbe_pkg::FRAC_W +: cbe_pkg::R_W];
  assign r_sat = r_val[cbe_pkg::R_W-1] ? '1 : r_val[cbe_pkg::COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ps_valid;
    end
    curve_coord <= {~r_sat[cbe_pkg::COORD_BITS-1], r_sat[cbe_pkg::COORD_BITS-2:0]};
  end

endmodule

// ===== rtl/cubic_bezier_point_eval_core.sv =====
// Path: a request accepted at a clock edge moves through the lvl1, lvl2, partial-product,
// partial-sum and done registers, five register stages, and then shows with done high.
// Throughput: one request per cycle; busy stays low, since every stage advances
// each cycle and the receiver takes each result in its one strobe cycle.
// Reset: synchronous rst clears the valid bits of all stages; data is not reset.
module cubic_bezier_point_eval_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [cbe_pkg::U_W-1:0]               u_param,
  input  logic signed [cbe_pkg::COORD_BITS-1:0] point_0,
  input  logic signed [cbe_pkg::COORD_BITS-1:0] point_1,
  input  logic signed [cbe_pkg::COORD_BITS-1:0] point_2,
  input  logic signed [cbe_pkg::COORD_BITS-1:0] point_3,
  output logic                                  done,
  output logic signed [cbe_pkg::COORD_BITS-1:0] curve_coord
);

  cbe_pkg::lvl1_t lvl1;
  cbe_pkg::lvl2_t lvl2;

  // The pipeline never holds a request off.
  assign busy = 1'b0;

  cbe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .u_param  (u_param),
    .point_0  (point_0),
    .point_1  (point_1),
    .point_2  (point_2),
    .point_3  (point_3),
    .lvl1     (lvl1)
  );

  cbe_mid u_mid (
    .clk  (clk),
    .rst  (rst),
    .lvl1 (lvl1),
    .lvl2 (lvl2)
  );

  cbe_tail u_tail (
    .clk         (clk),
    .rst         (rst),
    .lvl2        (lvl2),
    .done        (done),
    .curve_coord (curve_coord)
  );

`ifndef SYNTHESIS
  // Every result comes from an earlier request.
  a_done_from_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("result without a matching request");

  // At u equal to zero the curve sits on the last control point.
  a_u_zero_endpoint: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(u_param, 5) == '0)) |-> (curve_coord == $past(point_3, 5)))
    else $error("curve does not start on the last control point");

  // At u of one or more the curve sits on the first control point.
  a_u_one_endpoint: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(u_param, 5) >= cbe_pkg::PARAM_ONE))
      |-> (curve_coord == $past(point_0, 5)))
    else $error("curve does not end on the first control point");
`endif

endmodule

// ===== dv/tb.sv =====
module tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int TAIL_CYCLES  = 12;

  // One accepted request together with the coordinate it must produce.
  typedef struct {
    cbe_pkg::param_t u;
    cbe_pkg::coord_t p0;
    cbe_pkg::coord_t p1;
    cbe_pkg::coord_t p2;
    cbe_pkg::coord_t p3;
    cbe_pkg::coord_t coord;
  } coord_due_t;

  // Holds the coordinates still owed by the pipeline and checks each result.
  class bezier_scoreboard;
    coord_due_t pending_coords[$];
    int         n_checked;
    int         n_u_clipped;
    int         n_mismatch;

    function new();
      n_checked   = 0;
      n_u_clipped = 0;
      n_mismatch  = 0;
    endfunction

    // Bernstein form, exact in wide unsigned arithmetic on offset-binary points.
    static function cbe_pkg::coord_t bernstein_coord(cbe_pkg::param_t u_raw,
                                                     cbe_pkg::coord_t p0,
                                                     cbe_pkg::coord_t p1,
                                                     cbe_pkg::coord_t p2,
                                                     cbe_pkg::coord_t p3);
      logic [127:0]    uw;
      logic [127:0]    vw;
      logic [127:0]    q0;
      logic [127:0]    q1;
      logic [127:0]    q2;
      logic [127:0]    q3;
      logic [127:0]    acc;
      logic [127:0]    top;
      cbe_pkg::coord_t sign_bit;
      sign_bit = cbe_pkg::coord_t'(1) << (cbe_pkg::COORD_BITS - 1);
      uw  = (u_raw > cbe_pkg::PARAM_ONE) ? 128'(cbe_pkg::PARAM_ONE) : 128'(u_raw);
      vw  = 128'(cbe_pkg::PARAM_ONE) - uw;
      q0  = 128'(p0 ^ sign_bit);
      q1  = 128'(p1 ^ sign_bit);
      q2  = 128'(p2 ^ sign_bit);
      q3  = 128'(p3 ^ sign_bit);
      acc = q0 * uw * uw * uw + 128'(3) * q1 * uw * uw * vw
          + 128'(3) * q2 * uw * vw * vw + q3 * vw * vw * vw;
      acc = acc + (128'(1) << (cbe_pkg::FRAC_W - 1));
      acc = acc >> cbe_pkg::FRAC_W;
      top = (128'(1) << cbe_pkg::COORD_BITS) - 1;
      if (acc > top) acc = top;
      return cbe_pkg::coord_t'(acc) ^ sign_bit;
    endfunction

    function int pending();
      return pending_coords.size();
    endfunction

    // Called for every request the block takes.
    function void note_request(cbe_pkg::param_t u, cbe_pkg::coord_t p0,
                               cbe_pkg::coord_t p1, cbe_pkg::coord_t p2,
                               cbe_pkg::coord_t p3);
      coord_due_t item;
      item.u     = u;
      item.p0    = p0;
      item.p1    = p1;
      item.p2    = p2;
      item.p3    = p3;
      item.coord = bernstein_coord(u, p0, p1, p2, p3);
      if (u > cbe_pkg::PARAM_ONE) n_u_clipped++;
      pending_coords.push_back(item);
    endfunction

    // Prints one line per failure and counts every one.
    task report_mismatch(string msg);
      n_mismatch++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_coord(cbe_pkg::coord_t got);
      coord_due_t item;
      if (pending_coords.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request outstanding", $signed(got)));
      end else begin
        item = pending_coords.pop_front();
        n_checked++;
        if (got !== item.coord)
          report_mismatch($sformatf(
            "u=%0d p=%0d,%0d,%0d,%0d: curve_coord %0d, predicted %0d",
            item.u, $signed(item.p0), $signed(item.p1), $signed(item.p2),
            $signed(item.p3), $signed(got), $signed(item.coord)));
      end
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  cbe_pkg::param_t u_param = '0;
  cbe_pkg::coord_t point_0 = '0;
  cbe_pkg::coord_t point_1 = '0;
  cbe_pkg::coord_t point_2 = '0;
  cbe_pkg::coord_t point_3 = '0;
  logic            done;
  cbe_pkg::coord_t curve_coord;

  bezier_scoreboard sb = new();
  int               cycle_count;

  cubic_bezier_point_eval_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .u_param     (u_param),
    .point_0     (point_0),
    .point_1     (point_1),
    .point_2     (point_2),
    .point_3     (point_3),
    .done        (done),
    .curve_coord (curve_coord)
  );

  always #5 clk = ~clk;

  // Watch both handshakes on the edge that completes them.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(u_param, point_0, point_1, point_2, point_3);
      if (done) sb.check_coord(curve_coord);
    end
  end

  // Run-away guard.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(cbe_pkg::param_t u, cbe_pkg::coord_t a, cbe_pkg::coord_t b,
                              cbe_pkg::coord_t c, cbe_pkg::coord_t d);
    start   <= 1'b1;
    u_param <= u;
    point_0 <= a;
    point_1 <= b;
    point_2 <= c;
    point_3 <= d;
    do @(posedge clk); while (busy);
  endtask

  // Random idle cycles ahead of a request, roughly 38 percent of the time.
  task automatic idle_gap();
    while ($urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off until the pipeline has returned everything it owes.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic cbe_pkg::coord_t rand_coord();
    case ($urandom_range(9))
      0:       return cbe_pkg::coord_t'(16'sh8000);
      1:       return cbe_pkg::coord_t'(16'sh7fff);
      2:       return '0;
      3:       return '1;
      default: return cbe_pkg::coord_t'($urandom);
    endcase
  endfunction

  // Mostly interior parameters, with endpoints and values above one mixed in.
  function automatic cbe_pkg::param_t rand_param();
    case ($urandom_range(9))
      0:       return '0;
      1:       return cbe_pkg::PARAM_ONE;
      2:       return cbe_pkg::param_t'($urandom_range(int'(cbe_pkg::PARAM_ONE) + 1,
                                                       (1 << cbe_pkg::U_W) - 1));
      default: return cbe_pkg::param_t'($urandom_range(0, int'(cbe_pkg::PARAM_ONE) - 1));
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Endpoints pick out the last and first control points.
    send_request('0, 16'h1234, 16'h5555, 16'haaaa, 16'hfedc);
    send_request(cbe_pkg::PARAM_ONE, 16'h1234, 16'h5555, 16'haaaa, 16'hfedc);
    // Parameters above one are clipped to one.
    send_request(cbe_pkg::param_t'(cbe_pkg::PARAM_ONE + 1), 16'h0101, 16'h7fff, 16'h8000,
                 16'h4321);
    send_request('1, 16'hc001, 16'h7fff, 16'h8000, 16'h4321);
    send_request(17'h18000, 16'h0f0f, 16'h0000, 16'hffff, 16'h8000);
    // Smallest and largest proper fractions.
    send_request(17'd1, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_request(cbe_pkg::param_t'(cbe_pkg::PARAM_ONE - 1), 16'h7fff, 16'h8000, 16'h7fff,
                 16'h8000);
    // All points at the coordinate extremes.
    send_request(17'h08000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(17'h08000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(17'h05555, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(17'h0aaab, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    // Exact halves at u = 0.5 round toward plus infinity.
    send_request(17'h08000, 16'h0004, 16'h0000, 16'h0000, 16'h0000);
    send_request(17'h08000, 16'hfffc, 16'h0000, 16'h0000, 16'h0000);
    send_request(17'h08000, 16'h0000, 16'h0000, 16'h0000, 16'h0004);
    // Alternating values on all four points: the coordinate extremes, then minus one and one.
    send_request(17'h0c000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_request(17'h04000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_request(17'h00001, 16'hffff, 16'h0001, 16'hffff, 16'h0001);
    drain_pipeline();

    // Random requests, with a burst window that never idles and one full drain.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_pipeline();
      if (i < 300 || i >= 500) idle_gap();
      send_request(rand_param(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end

    // Let the pipeline empty, then keep watching for stray results.
    drain_pipeline();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d curve points, %0d with the parameter clipped to one",
             sb.n_checked, sb.n_u_clipped);
    $display("stimulus covered endpoints, rounding ties, extreme points and back-to-back bursts");
    if (sb.n_mismatch == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/cbe_pkg.sv
rtl/cbe_front.sv
rtl/cbe_mid.sv
rtl/cbe_tail.sv
rtl/cubic_bezier_point_eval_core.sv
dv/tb.sv
